### rtl/assert_macros.svh
// Assertion macros used by the console writer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CTW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define CTW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ctw_pkg.sv
// Types and constants for the text console cursor writer.
`timescale 1ns / 1ps
`default_nettype none
package ctw_pkg;

   localparam int OP_W        = 2;
   localparam int CHAR_W      = 8;
   localparam int POS_IN_W    = 8;
   localparam int CELL_ADDR_W = 11;
   localparam int CELL_DATA_W = 16;
   localparam int CUR_COL_W   = 7;
   localparam int CUR_ROW_W   = 5;
   localparam int COLOR_W     = 4;
   localparam int CSR_INDEX_W = 1;

   localparam logic [OP_W-1:0] OP_PUT_CHAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;
   localparam logic [OP_W-1:0] OP_SET_CURSOR = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FG_COLOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_COLOR = 1'd1;

   localparam logic [COLOR_W-1:0] FG_RESET = 4'd10;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   // Classified command, as the front hands it over.
   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_RETURN,
      CMD_TAB,
      CMD_BACKSPACE,
      CMD_CLEAR,
      CMD_SET_CURSOR,
      CMD_SKIP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [CHAR_W-1:0]     char_code;
      logic [POS_IN_W-1:0]   new_col;
      logic [POS_IN_W-1:0]   new_row;
   } cmd_type;

   typedef struct packed {
      logic                   cell_written;
      logic [CELL_ADDR_W-1:0] cell_address;
      logic [CELL_DATA_W-1:0] cell_data;
      logic [CUR_COL_W-1:0]   cursor_col;
      logic [CUR_ROW_W-1:0]   cursor_row;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/text_console_cursor_writer.sv
// Top level of the text console cursor writer.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | tuser op, tdata char/col/row
//  rsp     | out | rsp_tvalid / rsp_tready | tuser cell_written, tdata cell/cursor
//  csr     | in  | csr_valid / csr_ready   | csr_index, csr_data (colours)
//
// One request per cycle sustained while results are taken; a result passes the command
// queue register, then the result register, and is held until rsp_tready accepts it.
// The cursor register in the back end loops through the cursor update logic.
// Reset clears cursor, queue and result valid; colours return to their defaults.
// A stalled result holds the back end; the queue absorbs two requests meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module text_console_cursor_writer #(
   parameter int TEXT_COLS = 80,
   parameter int TEXT_ROWS = 25,
   parameter int TAB_STEP  = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [23:0]                        req_tdata,  // char_code, new_col, new_row
   input  wire logic [ctw_pkg::OP_W-1:0]           req_tuser,  // op
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [39:0]                             rsp_tdata,  // cell_address, cell_data,
                                                               // cursor_col, cursor_row, pad
   output logic                                    rsp_tuser,  // cell_written
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ctw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ctw_pkg::COLOR_W-1:0]        csr_data
);
   import ctw_pkg::*;

   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;
   cmd_type            front_cmd;
   cmd_type            queue_cmd;
   logic               queue_valid;
   logic               back_ready;
   rsp_type            rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FG_COLOR: fg_in = csr_data;
            CSR_BG_COLOR: bg_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   ctw_front #(
      .TEXT_COLS (TEXT_COLS),
      .TEXT_ROWS (TEXT_ROWS)
   ) u_front (
      .op        (req_tuser),
      .char_code (req_tdata[7:0]),
      .new_col   (req_tdata[15:8]),
      .new_row   (req_tdata[23:16]),
      .cmd       (front_cmd)
   );

   ctw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (queue_cmd)
   );

   ctw_back #(
      .TEXT_COLS (TEXT_COLS),
      .TEXT_ROWS (TEXT_ROWS),
      .TAB_STEP  (TAB_STEP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (back_ready),
      .cmd       (queue_cmd),
      .attr      ({bg_ff, fg_ff}),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.cell_written;
   assign rsp_tdata = {1'b0, rsp.cursor_row, rsp.cursor_col, rsp.cell_data, rsp.cell_address};

endmodule
`default_nettype wire

### rtl/ctw_front.sv
// Front end: decodes an incoming request into a console command.
`timescale 1ns / 1ps
`default_nettype none
module ctw_front #(
   parameter int TEXT_COLS = 80,
   parameter int TEXT_ROWS = 25
) (
   input  wire logic [ctw_pkg::OP_W-1:0]     op,
   input  wire logic [ctw_pkg::CHAR_W-1:0]   char_code,
   input  wire logic [ctw_pkg::POS_IN_W-1:0] new_col,
   input  wire logic [ctw_pkg::POS_IN_W-1:0] new_row,
   output ctw_pkg::cmd_type                  cmd
);
   import ctw_pkg::*;

   // limits fit in 9 bits for every legal geometry
   localparam logic [POS_IN_W:0] COLS_LIM = (POS_IN_W+1)'(TEXT_COLS);
   localparam logic [POS_IN_W:0] ROWS_LIM = (POS_IN_W+1)'(TEXT_ROWS);

   logic pos_ok;

   assign pos_ok = ({1'b0, new_col} < COLS_LIM) && ({1'b0, new_row} < ROWS_LIM);

   always_comb begin
      cmd.char_code = char_code;
      cmd.new_col   = new_col;
      cmd.new_row   = new_row;
      case (op)
         OP_PUT_CHAR: begin
            case (char_code)
               CH_NEWLINE: cmd.kind = CMD_NEWLINE;
               CH_RETURN:  cmd.kind = CMD_RETURN;
               CH_TAB:     cmd.kind = CMD_TAB;
               default:    cmd.kind = CMD_PUT;
            endcase
         end
         OP_BACKSPACE: cmd.kind = CMD_BACKSPACE;
         OP_CLEAR:     cmd.kind = CMD_CLEAR;
         OP_SET_CURSOR: cmd.kind = pos_ok ? CMD_SET_CURSOR : CMD_SKIP;
         default:      cmd.kind = CMD_SKIP;
      endcase
   end

endmodule
`default_nettype wire

### rtl/ctw_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module ctw_queue (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_valid,
   output logic            push_ready,
   input  wire ctw_pkg::cmd_type push_cmd,
   output logic            pop_valid,
   input  wire logic       pop_ready,
   output ctw_pkg::cmd_type pop_cmd
);
   import ctw_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

### rtl/ctw_back.sv
// Back end: cursor update, cell word and address, result register.
`timescale 1ns / 1ps
`default_nettype none
module ctw_back #(
   parameter int TEXT_COLS = 80,
   parameter int TEXT_ROWS = 25,
   parameter int TAB_STEP  = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               cmd_valid,
   output logic                                    cmd_ready,
   input  wire ctw_pkg::cmd_type                   cmd,
   input  wire logic [2*ctw_pkg::COLOR_W-1:0]      attr,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output ctw_pkg::rsp_type                        rsp
);
   import ctw_pkg::*;
`include "assert_macros.svh"

   localparam int COL_W  = $clog2(TEXT_COLS);
   localparam int ROW_W  = (TEXT_ROWS > 2) ? $clog2(TEXT_ROWS) : 1;
   localparam int STEP_W = COL_W + 5;
   localparam int AW     = (ROW_W + COL_W > CELL_ADDR_W) ? ROW_W + COL_W : CELL_ADDR_W;
   localparam logic [COL_W:0]    COLS_LIM  = (COL_W+1)'(TEXT_COLS);
   localparam logic [ROW_W:0]    ROWS_LIM  = (ROW_W+1)'(TEXT_ROWS);
   localparam logic [STEP_W-1:0] COLS_STEP = STEP_W'(TEXT_COLS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(TEXT_COLS - 1);
   localparam logic [AW-1:0]     COLS_AW   = AW'(TEXT_COLS);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              pop;
   logic [STEP_W-1:0] col_sum;
   logic [ROW_W:0]    row_inc;
   logic [ROW_W-1:0]  row_down;
   logic [COL_W-1:0]  wr_col;
   logic [ROW_W-1:0]  wr_row;
   logic [AW-1:0]     addr_calc;
   logic              writes;
   logic [CELL_DATA_W-1:0] word;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // next row, wrapping past the bottom to row 0
   assign row_inc  = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign row_down = (row_inc >= ROWS_LIM) ? '0 : row_inc[ROW_W-1:0];

   assign col_sum = STEP_W'(col_ff) +
                    ((cmd.kind == CMD_TAB) ? STEP_W'(TAB_STEP) : STEP_W'(1));

   assign addr_calc = AW'(wr_row) * COLS_AW + AW'(wr_col);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      wr_col = col_ff;
      wr_row = row_ff;
      writes = 1'b0;
      word   = '0;
      case (cmd.kind)
         CMD_PUT, CMD_TAB: begin
            if (cmd.kind == CMD_PUT) begin
               writes = 1'b1;
               word   = {attr, cmd.char_code};
            end
            if (col_sum >= COLS_STEP) begin
               col_in = '0;
               row_in = row_down;
            end else begin
               col_in = col_sum[COL_W-1:0];
            end
         end
         CMD_NEWLINE: begin
            col_in = '0;
            row_in = row_down;
         end
         CMD_RETURN: col_in = '0;
         CMD_BACKSPACE: begin
            if (col_ff != '0) begin
               col_in = col_ff - COL_W'(1);
               writes = 1'b1;
            end else if (row_ff != '0) begin
               col_in = LAST_COL;
               row_in = row_ff - ROW_W'(1);
               writes = 1'b1;
            end
            wr_col = col_in;
            wr_row = row_in;
            if (writes) begin
               word = {attr, CH_SPACE};
            end
         end
         CMD_CLEAR: begin
            col_in = '0;
            row_in = '0;
            word   = {attr, CH_SPACE};
         end
         CMD_SET_CURSOR: begin
            col_in = cmd.new_col[COL_W-1:0];
            row_in = cmd.new_row[ROW_W-1:0];
         end
         default: ;
      endcase

      rsp_in.cell_written = writes;
      rsp_in.cell_address = writes ? addr_calc[CELL_ADDR_W-1:0] : '0;
      rsp_in.cell_data    = word;
      rsp_in.cursor_col   = CUR_COL_W'(col_in);
      rsp_in.cursor_row   = CUR_ROW_W'(row_in);

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   `CTW_ASSERT(a_col_range, {1'b0, col_ff} < COLS_LIM, "cursor column out of range")
   `CTW_ASSERT(a_row_range, {1'b0, row_ff} < ROWS_LIM, "cursor row out of range")
   `CTW_ASSERT(a_no_overrun, !pop || !rsp_valid_ff || rsp_ready, "result overwritten")
   `CTW_ASSERT_NEXT(a_clear_home, pop && (cmd.kind == CMD_CLEAR), (col_ff == '0) && (row_ff == '0), "clear left cursor away from home")

endmodule
`default_nettype wire
